FILE: rtl/owbm_pkg.sv
// owbm_pkg: shared types, codes and timing constants of the 1-Wire bus master.
// No dependencies; every rtl file refers to it by scoped names.
package owbm_pkg;

	// Bus phases of the running command
	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_RST_LOW  = 4'd1,
		PH_RST_REC  = 4'd2,
		PH_RST_WIN  = 4'd3,
		PH_RST_TAIL = 4'd4,
		PH_WR_LOW   = 4'd5,
		PH_WR_REST  = 4'd6,
		PH_RD_LOW   = 4'd7,
		PH_RD_WAIT  = 4'd8,
		PH_RD_REST  = 4'd9
	} phase_t;

	// Request opcodes; codes 6 and 7 are ignored
	typedef enum logic [2:0] {
		OP_TICK       = 3'd0,
		OP_BUS_RESET  = 3'd1,
		OP_WRITE_BYTE = 3'd2,
		OP_READ_BYTE  = 3'd3,
		OP_WRITE_BIT  = 3'd4,
		OP_READ_BIT   = 3'd5,
		OP_NONE6      = 3'd6,
		OP_NONE7      = 3'd7
	} opcode_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_RESET_LOW     = 3'd0,
		CFG_RESET_RECOVER = 3'd1,
		CFG_PRESENCE_WIN  = 3'd2,
		CFG_WR1_LOW       = 3'd3,
		CFG_WR1_REST      = 3'd4,
		CFG_WR0_LOW       = 3'd5,
		CFG_RD_LOW        = 3'd6,
		CFG_RD_SAMPLE     = 3'd7
	} cfg_idx_t;

	localparam int unsigned CNT_W      = 10;
	localparam int unsigned SHORT_W    = 7;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned BITS_W     = 4;
	localparam int unsigned CFG_DATA_W = CNT_W;

	// Fixed times in microseconds
	localparam logic [CNT_W-1:0] RESET_TAIL_US   = 10'd10;
	localparam logic [CNT_W-1:0] ZERO_RECOVER_US = 10'd10;
	localparam logic [CNT_W-1:0] READ_REST_US    = 10'd70;

	localparam logic [BITS_W-1:0] BITS_BYTE = 4'd8;
	localparam logic [BITS_W-1:0] BITS_ONE  = 4'd1;

	// Register reset values
	localparam logic [CNT_W-1:0]   RST_RESET_LOW     = 10'd550;
	localparam logic [CNT_W-1:0]   RST_RESET_RECOVER = 10'd50;
	localparam logic [CNT_W-1:0]   RST_PRESENCE_WIN  = 10'd100;
	localparam logic [SHORT_W-1:0] RST_WR1_LOW       = 7'd8;
	localparam logic [SHORT_W-1:0] RST_WR1_REST      = 7'd70;
	localparam logic [SHORT_W-1:0] RST_WR0_LOW       = 7'd70;
	localparam logic [SHORT_W-1:0] RST_RD_LOW        = 7'd10;
	localparam logic [SHORT_W-1:0] RST_RD_SAMPLE     = 7'd5;

	typedef struct packed {
		logic [CNT_W-1:0]   reset_low_us;
		logic [CNT_W-1:0]   reset_recovery_us;
		logic [CNT_W-1:0]   presence_window_us;
		logic [SHORT_W-1:0] write_one_low_us;
		logic [SHORT_W-1:0] write_one_rest_us;
		logic [SHORT_W-1:0] write_zero_low_us;
		logic [SHORT_W-1:0] read_low_us;
		logic [SHORT_W-1:0] read_sample_us;
	} cfg_t;

	typedef struct packed {
		logic              drive_low;
		logic              busy_res;
		logic              done_res;
		logic              presence;
		logic [BYTE_W-1:0] read_data;
		logic              rejected;
	} result_t;

	// A zero length counts as one microsecond
	function automatic logic [CNT_W-1:0] len_us(input logic [CNT_W-1:0] v);
		return (v == '0) ? 10'd1 : v;
	endfunction

	function automatic logic [CNT_W-1:0] len_short(input logic [SHORT_W-1:0] v);
		return len_us({{(CNT_W-SHORT_W){1'b0}}, v});
	endfunction

endpackage

FILE: rtl/owbm_if.sv
// owbm_if: valid/ready channel interfaces for requests and results.
// Depends on owbm_pkg for field widths.
interface owbm_req_if;
	logic                           valid;
	logic                           ready;
	logic [2:0]                     opcode;
	logic [owbm_pkg::BYTE_W-1:0]    data_in;
	logic                           line_level;

	modport source (output valid, output opcode, output data_in, output line_level,
		input ready);
	modport sink (input valid, input opcode, input data_in, input line_level,
		output ready);
endinterface

interface owbm_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           drive_low;
	logic                           busy_res;
	logic                           done_res;
	logic                           presence;
	logic [owbm_pkg::BYTE_W-1:0]    read_data;
	logic                           rejected;

	modport source (output valid, output drive_low, output busy_res, output done_res,
		output presence, output read_data, output rejected, input ready);
	modport sink (input valid, input drive_low, input busy_res, input done_res,
		input presence, input read_data, input rejected, output ready);
endinterface

FILE: rtl/owbm_cfg_regs.sv
// owbm_cfg_regs: timing register file written through a plain write port.
// Depends on owbm_pkg (cfg_t, register indexes, reset values).
module owbm_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              we,
	input  logic [2:0]                        index,
	input  logic [owbm_pkg::CFG_DATA_W-1:0]   wdata,
	output owbm_pkg::cfg_t                    cfg
);

	owbm_pkg::cfg_t cfg_q;

	// Update the addressed register, keep the rest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_us       <= owbm_pkg::RST_RESET_LOW;
			cfg_q.reset_recovery_us  <= owbm_pkg::RST_RESET_RECOVER;
			cfg_q.presence_window_us <= owbm_pkg::RST_PRESENCE_WIN;
			cfg_q.write_one_low_us   <= owbm_pkg::RST_WR1_LOW;
			cfg_q.write_one_rest_us  <= owbm_pkg::RST_WR1_REST;
			cfg_q.write_zero_low_us  <= owbm_pkg::RST_WR0_LOW;
			cfg_q.read_low_us        <= owbm_pkg::RST_RD_LOW;
			cfg_q.read_sample_us     <= owbm_pkg::RST_RD_SAMPLE;
		end else if (we) begin
			case (owbm_pkg::cfg_idx_t'(index))
				owbm_pkg::CFG_RESET_LOW:     cfg_q.reset_low_us       <= wdata;
				owbm_pkg::CFG_RESET_RECOVER: cfg_q.reset_recovery_us  <= wdata;
				owbm_pkg::CFG_PRESENCE_WIN:  cfg_q.presence_window_us <= wdata;
				owbm_pkg::CFG_WR1_LOW:
					cfg_q.write_one_low_us  <= wdata[owbm_pkg::SHORT_W-1:0];
				owbm_pkg::CFG_WR1_REST:
					cfg_q.write_one_rest_us <= wdata[owbm_pkg::SHORT_W-1:0];
				owbm_pkg::CFG_WR0_LOW:
					cfg_q.write_zero_low_us <= wdata[owbm_pkg::SHORT_W-1:0];
				owbm_pkg::CFG_RD_LOW:
					cfg_q.read_low_us       <= wdata[owbm_pkg::SHORT_W-1:0];
				owbm_pkg::CFG_RD_SAMPLE:
					cfg_q.read_sample_us    <= wdata[owbm_pkg::SHORT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/owbm_core.sv
// owbm_core: bus phase sequencer; one request updates the state in one pass.
// Depends on owbm_pkg (phase_t, opcode_t, cfg_t, result_t, len helpers).
module owbm_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [2:0]                     opcode,
	input  logic [owbm_pkg::BYTE_W-1:0]    data_in,
	input  logic                           line_level,
	input  owbm_pkg::cfg_t                 cfg,
	output owbm_pkg::result_t              result
);

	owbm_pkg::phase_t                 phase_q, phase_d;
	logic [owbm_pkg::CNT_W-1:0]       cnt_q, cnt_d;
	logic [owbm_pkg::BYTE_W-1:0]      shift_q, shift_d;
	logic [owbm_pkg::BITS_W-1:0]      bits_q, bits_d;
	logic [2:0]                       kind_q, kind_d;
	logic                             pres_q, pres_d;
	logic                             done, rej;

	logic [owbm_pkg::CNT_W-1:0]       cnt_dec;
	logic [owbm_pkg::BITS_W-1:0]      bits_dec;
	logic [owbm_pkg::BYTE_W-1:0]      shift_sh;
	logic                             is_idle;

	assign cnt_dec  = cnt_q - 10'd1;
	assign bits_dec = bits_q - 4'd1;
	assign shift_sh = {1'b0, shift_q[owbm_pkg::BYTE_W-1:1]};
	assign is_idle  = (phase_q == owbm_pkg::PH_IDLE);

	// Next state: tick advances the countdown, a command starts from idle and is rejected while busy
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		shift_d = shift_q;
		bits_d  = bits_q;
		kind_d  = kind_q;
		pres_d  = pres_q;
		done    = 1'b0;
		rej     = 1'b0;
		case (owbm_pkg::opcode_t'(opcode))
			owbm_pkg::OP_TICK: begin
				if (!is_idle) begin
					if (phase_q == owbm_pkg::PH_RST_WIN && !line_level) begin
						pres_d = 1'b1;
					end
					cnt_d = cnt_dec;
					if (cnt_dec == '0) begin
						case (phase_q)
							owbm_pkg::PH_RST_LOW: begin
								phase_d = owbm_pkg::PH_RST_REC;
								cnt_d   = owbm_pkg::len_us(cfg.reset_recovery_us);
							end
							owbm_pkg::PH_RST_REC: begin
								phase_d = owbm_pkg::PH_RST_WIN;
								cnt_d   = owbm_pkg::len_us(cfg.presence_window_us);
							end
							owbm_pkg::PH_RST_WIN: begin
								phase_d = owbm_pkg::PH_RST_TAIL;
								cnt_d   = owbm_pkg::RESET_TAIL_US;
							end
							owbm_pkg::PH_WR_LOW: begin
								phase_d = owbm_pkg::PH_WR_REST;
								cnt_d   = shift_q[0] ?
									owbm_pkg::len_short(cfg.write_one_rest_us) :
									owbm_pkg::ZERO_RECOVER_US;
							end
							owbm_pkg::PH_WR_REST: begin
								shift_d = shift_sh;
								bits_d  = bits_dec;
								if (bits_dec != '0) begin
									phase_d = owbm_pkg::PH_WR_LOW;
									cnt_d   = shift_sh[0] ?
										owbm_pkg::len_short(cfg.write_one_low_us) :
										owbm_pkg::len_short(cfg.write_zero_low_us);
								end else begin
									done = 1'b1;
								end
							end
							owbm_pkg::PH_RD_LOW: begin
								phase_d = owbm_pkg::PH_RD_WAIT;
								cnt_d   = owbm_pkg::len_short(cfg.read_sample_us);
							end
							owbm_pkg::PH_RD_WAIT: begin
								if (owbm_pkg::opcode_t'(kind_q) == owbm_pkg::OP_READ_BIT) begin
									shift_d = {{(owbm_pkg::BYTE_W-1){1'b0}}, line_level};
								end else begin
									shift_d = {line_level, shift_q[owbm_pkg::BYTE_W-1:1]};
								end
								phase_d = owbm_pkg::PH_RD_REST;
								cnt_d   = owbm_pkg::READ_REST_US;
							end
							owbm_pkg::PH_RD_REST: begin
								bits_d = bits_dec;
								if (bits_dec != '0) begin
									phase_d = owbm_pkg::PH_RD_LOW;
									cnt_d   = owbm_pkg::len_short(cfg.read_low_us);
								end else begin
									done = 1'b1;
								end
							end
							default: begin
								done = 1'b1;
							end
						endcase
						if (done) begin
							phase_d = owbm_pkg::PH_IDLE;
							cnt_d   = '0;
						end
					end
				end
			end
			owbm_pkg::OP_BUS_RESET, owbm_pkg::OP_WRITE_BYTE, owbm_pkg::OP_READ_BYTE,
			owbm_pkg::OP_WRITE_BIT, owbm_pkg::OP_READ_BIT: begin
				if (!is_idle) begin
					rej = 1'b1;
				end else begin
					kind_d = opcode;
					case (owbm_pkg::opcode_t'(opcode))
						owbm_pkg::OP_BUS_RESET: begin
							pres_d  = 1'b0;
							bits_d  = '0;
							phase_d = owbm_pkg::PH_RST_LOW;
							cnt_d   = owbm_pkg::len_us(cfg.reset_low_us);
						end
						owbm_pkg::OP_WRITE_BYTE: begin
							shift_d = data_in;
							bits_d  = owbm_pkg::BITS_BYTE;
							phase_d = owbm_pkg::PH_WR_LOW;
							cnt_d   = data_in[0] ?
								owbm_pkg::len_short(cfg.write_one_low_us) :
								owbm_pkg::len_short(cfg.write_zero_low_us);
						end
						owbm_pkg::OP_WRITE_BIT: begin
							shift_d = {{(owbm_pkg::BYTE_W-1){1'b0}}, data_in[0]};
							bits_d  = owbm_pkg::BITS_ONE;
							phase_d = owbm_pkg::PH_WR_LOW;
							cnt_d   = data_in[0] ?
								owbm_pkg::len_short(cfg.write_one_low_us) :
								owbm_pkg::len_short(cfg.write_zero_low_us);
						end
						owbm_pkg::OP_READ_BYTE: begin
							shift_d = '0;
							bits_d  = owbm_pkg::BITS_BYTE;
							phase_d = owbm_pkg::PH_RD_LOW;
							cnt_d   = owbm_pkg::len_short(cfg.read_low_us);
						end
						default: begin
							shift_d = '0;
							bits_d  = owbm_pkg::BITS_ONE;
							phase_d = owbm_pkg::PH_RD_LOW;
							cnt_d   = owbm_pkg::len_short(cfg.read_low_us);
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	// Result fields as seen after this request
	always_comb begin
		result.drive_low = (phase_d == owbm_pkg::PH_RST_LOW) ||
			(phase_d == owbm_pkg::PH_WR_LOW) || (phase_d == owbm_pkg::PH_RD_LOW);
		result.busy_res  = (phase_d != owbm_pkg::PH_IDLE);
		result.done_res  = done;
		result.presence  = pres_d;
		result.read_data = (done && ((owbm_pkg::opcode_t'(kind_q) == owbm_pkg::OP_READ_BYTE) ||
			(owbm_pkg::opcode_t'(kind_q) == owbm_pkg::OP_READ_BIT))) ? shift_d : '0;
		result.rejected  = rej;
	end

	// Hold state between requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= owbm_pkg::PH_IDLE;
			cnt_q   <= '0;
			shift_q <= '0;
			bits_q  <= '0;
			kind_q  <= '0;
			pres_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			shift_q <= shift_d;
			bits_q  <= bits_d;
			kind_q  <= kind_d;
			pres_q  <= pres_d;
		end
	end

endmodule

FILE: rtl/owbm_rsp_reg.sv
// owbm_rsp_reg: result output register with valid/ready handshake.
// Depends on owbm_pkg (result_t) and owbm_rsp_if.
module owbm_rsp_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  owbm_pkg::result_t     result,
	output logic                  can_load,
	owbm_rsp_if.source            rsp
);

	logic              valid_q;
	owbm_pkg::result_t data_q;

	// Take a new result when empty or when the held one leaves this cycle
	assign can_load = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			data_q <= result;
		end
	end

	assign rsp.valid     = valid_q;
	assign rsp.drive_low = data_q.drive_low;
	assign rsp.busy_res  = data_q.busy_res;
	assign rsp.done_res  = data_q.done_res;
	assign rsp.presence  = data_q.presence;
	assign rsp.read_data = data_q.read_data;
	assign rsp.rejected  = data_q.rejected;

endmodule

FILE: rtl/one_wire_bus_master.sv
// one_wire_bus_master: timed 1-Wire bus master, top level.
// Depends on owbm_pkg, owbm_if, owbm_cfg_regs, owbm_core, owbm_rsp_reg.
//
// Usage:
//   req carries one request per item: a one-microsecond tick with the sampled
//   line level, or a command (bus reset, write/read byte, write/read bit).
//   rsp returns exactly one result per request: drive_low, busy, done,
//   presence, read data and a rejected flag for a command sent while busy.
//   The cfg write port (cfg_we, cfg_index, cfg_wdata) sets the eight timing
//   registers; write it only while no request is outstanding.
// Timing and rate:
//   A result appears on rsp in the cycle after its request is accepted. One
//   request per cycle is sustained while rsp is not stalled; the phase countdown
//   and next-phase logic are combinational ahead of the output register.
// Reset:
//   arst_n returns the bus to idle (released), clears presence and loads the
//   default timings; the result register comes up empty.
// Stall:
//   When rsp is stalled the held result stays; req.ready stays high while the
//   output register is empty or draining, and drops otherwise.
module one_wire_bus_master (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [2:0]                        cfg_index,
	input  logic [owbm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	owbm_req_if.sink                          req,
	owbm_rsp_if.source                        rsp
);

	owbm_pkg::cfg_t    cfg;
	owbm_pkg::result_t result;
	logic              can_load;
	logic              accept;

	assign req.ready = can_load;
	assign accept    = req.valid && can_load;

	owbm_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	owbm_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.opcode     (req.opcode),
		.data_in    (req.data_in),
		.line_level (req.line_level),
		.cfg        (cfg),
		.result     (result)
	);

	owbm_rsp_reg u_rsp (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.result   (result),
		.can_load (can_load),
		.rsp      (rsp)
	);

endmodule

FILE: rtl/owbm_checker.sv
// owbm_checker: port-level checks on the result channel of the bus master.
// Depends on owbm_pkg; bound to one_wire_bus_master at the end of this file.
module owbm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input logic                            drive_low,
	input logic                            busy_res,
	input logic                            done_res,
	input logic [owbm_pkg::BYTE_W-1:0]     read_data,
	input logic                            rejected
);

	// Pulling the bus low only happens inside a command
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && drive_low |-> busy_res)
		else $error("drive_low without busy");

	// A finishing command leaves the block idle and is never a rejection
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && done_res |-> !busy_res && !rejected)
		else $error("done with busy or rejected");

	// Rejection only while a command runs
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rejected |-> busy_res)
		else $error("rejected while idle");

	// Read data is zero except on the finishing result
	a_data_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (read_data != '0) |-> done_res)
		else $error("read data outside done");

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data) && $stable(done_res))
		else $error("stalled result changed");

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.drive_low (rsp.drive_low),
	.busy_res  (rsp.busy_res),
	.done_res  (rsp.done_res),
	.read_data (rsp.read_data),
	.rejected  (rsp.rejected)
);
